FILE: design/uart_rx_tx_ring_buffers_unit_assert.svh
// ============================================================================
// Assertion macros
// Clocked assertion helpers with asynchronous active-low reset disable.
// ============================================================================
`ifndef UART_RX_TX_RING_BUFFERS_UNIT_ASSERT_SVH
`define UART_RX_TX_RING_BUFFERS_UNIT_ASSERT_SVH

// label: property checked on every rising clock edge outside reset
`define URB_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("urb assertion failed");

// label: condition a implies condition b in the next cycle
`define URB_ASSERT_NEXT(label, clk, rst_n, a, b) \
	`URB_ASSERT(label, clk, rst_n, (a) |=> (b))

`endif

FILE: design/urb_pkg.sv
// ============================================================================
// urb_pkg
// Shared types and constants of the serial port ring buffer unit.
// ============================================================================
package urb_pkg;

	localparam int RX_DEPTH_DEF = 8;
	localparam int TX_DEPTH_DEF = 8;

	localparam int ACTION_W   = 2;
	localparam int BYTE_W     = 8;
	localparam int RX_LEVEL_W = 8;
	localparam int TX_LEVEL_W = 9;

	typedef logic [ACTION_W-1:0] action_t;
	typedef logic [BYTE_W-1:0]   byte_t;

	localparam action_t ACT_RX_BYTE = 2'd0;
	localparam action_t ACT_TX_DONE = 2'd1;
	localparam action_t ACT_READ    = 2'd2;
	localparam action_t ACT_WRITE   = 2'd3;

	typedef struct packed {
		logic rd;
		logic push;
		logic pop;
	} ring_cmd_t;

endpackage

FILE: design/urb_if.sv
// ============================================================================
// urb_if
// Valid/ready channels for events in and results out.
// ============================================================================
interface urb_evt_if;
	import urb_pkg::*;

	logic    valid;
	logic    ready;
	action_t action;
	byte_t   rx_byte;
	logic    rx_error;
	byte_t   host_byte;
	logic    data_reg_empty;

	modport source (output valid, action, rx_byte, rx_error, host_byte, data_reg_empty,
		input ready);
	modport sink (input valid, action, rx_byte, rx_error, host_byte, data_reg_empty,
		output ready);
endinterface

interface urb_res_if;
	import urb_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  read_valid;
	byte_t                 read_data;
	logic                  write_accepted;
	logic                  send_valid;
	byte_t                 send_byte;
	logic                  overflow;
	logic [RX_LEVEL_W-1:0] rx_level;
	logic [TX_LEVEL_W-1:0] tx_level;

	modport source (output valid, read_valid, read_data, write_accepted, send_valid,
		send_byte, overflow, rx_level, tx_level, input ready);
	modport sink (input valid, read_valid, read_data, write_accepted, send_valid,
		send_byte, overflow, rx_level, tx_level, output ready);
endinterface

FILE: design/urb_ring.sv
// ============================================================================
// urb_ring
// Byte ring storage: synchronous memory with write and read pointers.
// ============================================================================
module urb_ring #(
	parameter int DEPTH = urb_pkg::RX_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  urb_pkg::ring_cmd_t  cmd,
	input  urb_pkg::byte_t      wdata,
	output urb_pkg::byte_t      rdata
);
	import urb_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	byte_t         mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	byte_t         rdata_q;

	function automatic logic [AW-1:0] advance(input logic [AW-1:0] ptr);
		return (ptr == AW'(DEPTH - 1)) ? '0 : ptr + AW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (cmd.push) begin
				wr_ptr_q <= advance(wr_ptr_q);
			end
			if (cmd.pop) begin
				rd_ptr_q <= advance(rd_ptr_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wr_ptr_q] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= mem[rd_ptr_q];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/urb_ctrl.sv
// ============================================================================
// urb_ctrl
// Event decode, level counters, overflow flag and result register.
// ============================================================================
module urb_ctrl #(
	parameter int RX_DEPTH = urb_pkg::RX_DEPTH_DEF,
	parameter int TX_DEPTH = urb_pkg::TX_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	urb_evt_if.sink            evt,
	urb_res_if.source          res,
	output urb_pkg::ring_cmd_t rx_cmd,
	output urb_pkg::ring_cmd_t tx_cmd,
	output urb_pkg::byte_t     rx_wdata,
	output urb_pkg::byte_t     tx_wdata,
	input  urb_pkg::byte_t     rx_rdata,
	input  urb_pkg::byte_t     tx_rdata
);
	import urb_pkg::*;

	localparam int RX_CW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
	localparam int TX_CW = $clog2(TX_DEPTH + 1);

	logic    valid_s1;
	action_t action_s1;
	byte_t   rx_byte_s1;
	logic    rx_error_s1;
	byte_t   host_byte_s1;
	logic    dre_s1;

	logic [RX_CW-1:0] rx_cnt_q;
	logic [TX_CW-1:0] tx_cnt_q;
	logic             ovf_q;

	logic                  res_valid_q;
	logic                  read_valid_q;
	byte_t                 read_data_q;
	logic                  write_acc_q;
	logic                  send_valid_q;
	byte_t                 send_byte_q;
	logic                  ovf_out_q;
	logic [RX_LEVEL_W-1:0] rx_level_q;
	logic [TX_LEVEL_W-1:0] tx_level_q;

	logic             accept;
	logic             fire;
	logic             rx_push, rx_pop, tx_push, tx_pop;
	logic             read_valid, write_acc, send_valid;
	byte_t            read_data, send_byte;
	logic [RX_CW:0]   rx_inc;
	logic [RX_CW-1:0] rx_cnt_nx;
	logic [TX_CW-1:0] tx_cnt_nx;
	logic             ovf_nx;

	assign evt.ready = !valid_s1;
	assign accept    = evt.valid && !valid_s1;
	assign fire      = valid_s1 && (!res_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1    <= evt.action;
			rx_byte_s1   <= evt.rx_byte;
			rx_error_s1  <= evt.rx_error;
			host_byte_s1 <= evt.host_byte;
			dre_s1       <= evt.data_reg_empty;
		end
	end

	assign rx_inc = {1'b0, rx_cnt_q} + (RX_CW + 1)'(1);

	always_comb begin
		rx_push    = 1'b0;
		rx_pop     = 1'b0;
		tx_push    = 1'b0;
		tx_pop     = 1'b0;
		read_valid = 1'b0;
		read_data  = '0;
		write_acc  = 1'b0;
		send_valid = 1'b0;
		send_byte  = '0;
		rx_cnt_nx  = rx_cnt_q;
		tx_cnt_nx  = tx_cnt_q;
		ovf_nx     = ovf_q;
		unique case (action_s1)
			ACT_RX_BYTE: begin
				if (!rx_error_s1) begin
					rx_push = 1'b1;
					if (rx_inc == (RX_CW + 1)'(RX_DEPTH)) begin
						rx_cnt_nx = '0;
						ovf_nx    = 1'b1;
					end else begin
						rx_cnt_nx = rx_inc[RX_CW-1:0];
					end
				end
			end
			ACT_TX_DONE: begin
				if (tx_cnt_q != '0) begin
					tx_pop     = 1'b1;
					send_valid = 1'b1;
					send_byte  = tx_rdata;
					tx_cnt_nx  = tx_cnt_q - TX_CW'(1);
				end
			end
			ACT_READ: begin
				if (rx_cnt_q != '0) begin
					rx_pop     = 1'b1;
					read_valid = 1'b1;
					read_data  = rx_rdata;
					rx_cnt_nx  = rx_cnt_q - RX_CW'(1);
				end
			end
			ACT_WRITE: begin
				if (tx_cnt_q != TX_CW'(TX_DEPTH)) begin
					write_acc = 1'b1;
					if (tx_cnt_q != '0 || !dre_s1) begin
						tx_push   = 1'b1;
						tx_cnt_nx = tx_cnt_q + TX_CW'(1);
					end else begin
						send_valid = 1'b1;
						send_byte  = host_byte_s1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign rx_cmd   = '{rd: accept, push: fire && rx_push, pop: fire && rx_pop};
	assign tx_cmd   = '{rd: accept, push: fire && tx_push, pop: fire && tx_pop};
	assign rx_wdata = rx_byte_s1;
	assign tx_wdata = host_byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_cnt_q    <= '0;
			tx_cnt_q    <= '0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				rx_cnt_q    <= rx_cnt_nx;
				tx_cnt_q    <= tx_cnt_nx;
				ovf_q       <= ovf_nx;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			read_valid_q <= read_valid;
			read_data_q  <= read_data;
			write_acc_q  <= write_acc;
			send_valid_q <= send_valid;
			send_byte_q  <= send_byte;
			ovf_out_q    <= ovf_nx;
			rx_level_q   <= RX_LEVEL_W'(rx_cnt_nx);
			tx_level_q   <= TX_LEVEL_W'(tx_cnt_nx);
		end
	end

	assign res.valid          = res_valid_q;
	assign res.read_valid     = read_valid_q;
	assign res.read_data      = read_data_q;
	assign res.write_accepted = write_acc_q;
	assign res.send_valid     = send_valid_q;
	assign res.send_byte      = send_byte_q;
	assign res.overflow       = ovf_out_q;
	assign res.rx_level       = rx_level_q;
	assign res.tx_level       = tx_level_q;

endmodule

FILE: design/uart_rx_tx_ring_buffers_unit.sv
// ============================================================================
// uart_rx_tx_ring_buffers_unit
// Receive and transmit byte rings of a serial port, one event per transfer.
// ============================================================================
// The evt channel carries one event per transfer: a received byte, a transmit
// complete, a host read or a host write, with the data and status bits that
// event uses. The res channel returns exactly one result per event: read
// data, write acceptance, the byte handed to the transmitter, the sticky
// overflow flag and both buffer levels after the event.
// Each ring lives in a synchronous memory that is read as the event is taken
// into the stage register; the result is then computed and the memory written
// back as it moves into the result register. One event is in its stage at a
// time, so no new event is taken until the last one has left that stage.
// The result register lets the next event enter while a result waits; if the
// receiver stalls, the following event holds in its stage until the result
// register drains, and evt.ready stays low meanwhile.
// Reset clears pointers, level counters, the overflow flag and the stage and
// result valid bits; the memory contents stay undefined, unused until written.
// ============================================================================
module uart_rx_tx_ring_buffers_unit #(
	parameter int RX_DEPTH = urb_pkg::RX_DEPTH_DEF,
	parameter int TX_DEPTH = urb_pkg::TX_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	urb_evt_if.sink   evt,
	urb_res_if.source res
);
	import urb_pkg::*;

	ring_cmd_t rx_cmd;
	ring_cmd_t tx_cmd;
	byte_t     rx_wdata;
	byte_t     tx_wdata;
	byte_t     rx_rdata;
	byte_t     tx_rdata;

	urb_ctrl #(
		.RX_DEPTH(RX_DEPTH),
		.TX_DEPTH(TX_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt      (evt),
		.res      (res),
		.rx_cmd   (rx_cmd),
		.tx_cmd   (tx_cmd),
		.rx_wdata (rx_wdata),
		.tx_wdata (tx_wdata),
		.rx_rdata (rx_rdata),
		.tx_rdata (tx_rdata)
	);

	urb_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (rx_cmd),
		.wdata  (rx_wdata),
		.rdata  (rx_rdata)
	);

	urb_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (tx_cmd),
		.wdata  (tx_wdata),
		.rdata  (tx_rdata)
	);

endmodule

FILE: design/urb_check.sv
// ============================================================================
// urb_check
// Port-level checks of the ring buffer unit, bound to the top level.
// ============================================================================
`include "uart_rx_tx_ring_buffers_unit_assert.svh"

module urb_check (
	input logic clk,
	input logic arst_n,
	input logic evt_valid,
	input logic evt_ready,
	input logic res_valid,
	input logic res_ready,
	input logic read_valid,
	input logic write_accepted,
	input logic send_valid,
	input logic overflow
);

	`URB_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)
	`URB_ASSERT_NEXT(a_one_in_flight, clk, arst_n, evt_valid && evt_ready, !evt_ready)
	`URB_ASSERT_NEXT(a_ovf_sticky, clk, arst_n, res_valid && res_ready && overflow,
		!res_valid || overflow)
	`URB_ASSERT(a_read_alone, clk, arst_n,
		res_valid && read_valid |-> !write_accepted && !send_valid)

endmodule

bind uart_rx_tx_ring_buffers_unit urb_check u_check (
	.clk            (clk),
	.arst_n         (arst_n),
	.evt_valid      (evt.valid),
	.evt_ready      (evt.ready),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.read_valid     (res.read_valid),
	.write_accepted (res.write_accepted),
	.send_valid     (res.send_valid),
	.overflow       (res.overflow)
);
